@@ rtl/jts_pkg.sv @@
// Package for the JSON token scanner: token and cause codes, character codes,
// keyword tables, scanner state types and saturating counter helpers.
// No dependencies; every other file of the scanner but jts_in_if imports it.
`default_nettype none

package jts_pkg;

  localparam int POS_BITS   = 32;
  localparam int LINE_BITS  = 32;
  localparam int MAX_RES    = 5;
  localparam int CNT_W      = $clog2(MAX_RES + 1);
  localparam int KW_MAX_LEN = 5;
  localparam int KW_IDX_W   = $clog2(KW_MAX_LEN + 1);
  localparam int NUM_CAND   = 9;

  typedef enum logic [3:0] {
    TK_LBRACE   = 4'd0,
    TK_RBRACE   = 4'd1,
    TK_LBRACKET = 4'd2,
    TK_RBRACKET = 4'd3,
    TK_COMMA    = 4'd4,
    TK_COLON    = 4'd5,
    TK_STRING   = 4'd6,
    TK_NUMBER   = 4'd7,
    TK_TRUE     = 4'd8,
    TK_FALSE    = 4'd9,
    TK_NULL     = 4'd10,
    TK_END      = 4'd11,
    TK_ERROR    = 4'd12
  } tok_kind_e;

  typedef enum logic [2:0] {
    EC_NONE         = 3'd0,
    EC_UNEXPECTED   = 3'd1,
    EC_UNTERMINATED = 3'd2,
    EC_BAD_BOOL     = 3'd3,
    EC_BAD_NULL     = 3'd4
  } err_cause_e;

  // One-hot scan modes.
  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_INT     = 6'b000010,
    MODE_DOT     = 6'b000100,
    MODE_FRAC    = 6'b001000,
    MODE_STRING  = 6'b010000,
    MODE_KEYWORD = 6'b100000
  } mode_e;

  // Keyword selectors.
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_A        = 8'h61;
  localparam logic [7:0] CH_E        = 8'h65;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_L        = 8'h6C;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_R        = 8'h72;
  localparam logic [7:0] CH_S        = 8'h73;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_U        = 8'h75;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  localparam logic [7:0] KW_TEXT [4][KW_MAX_LEN] = '{
    '{CH_T, CH_R, CH_U, CH_E, CH_NUL},
    '{CH_F, CH_A, CH_L, CH_S, CH_E},
    '{CH_N, CH_U, CH_L, CH_L, CH_NUL},
    '{CH_N, CH_U, CH_L, CH_L, CH_NUL}
  };
  localparam logic [KW_IDX_W-1:0] KW_LEN [4] = '{
    KW_IDX_W'(4), KW_IDX_W'(5), KW_IDX_W'(4), KW_IDX_W'(4)
  };
  localparam err_cause_e KW_CAUSE [4] = '{EC_BAD_BOOL, EC_BAD_BOOL, EC_BAD_NULL, EC_BAD_NULL};
  localparam tok_kind_e  KW_TOKEN [4] = '{TK_TRUE, TK_FALSE, TK_NULL, TK_NULL};

  typedef struct packed {
    tok_kind_e           kind;
    err_cause_e          cause;
    logic [POS_BITS-1:0] offset;
    logic [POS_BITS-1:0] length;
  } token_t;

  typedef token_t [MAX_RES-1:0] tok_list_t;

  typedef struct packed {
    mode_e                mode;
    logic [POS_BITS-1:0]  pos;
    logic [LINE_BITS-1:0] line;
    logic [POS_BITS-1:0]  tbegin;
    logic [7:0]           prev;
    logic [1:0]           kw_kind;
    logic [KW_IDX_W-1:0]  kw_matched;
  } scan_state_t;

  // What a byte does when it arrives between tokens.
  typedef struct packed {
    logic       emit;
    tok_kind_e  kind;
    err_cause_e cause;
    logic       newline;
    logic       start;
    mode_e      mode;
    logic [1:0] kw_kind;
  } idle_act_t;

  function automatic idle_act_t idle_decode(logic [7:0] b);
    idle_act_t a;
    a = '{emit: 1'b0, kind: TK_ERROR, cause: EC_NONE, newline: 1'b0, start: 1'b0,
          mode: MODE_IDLE, kw_kind: KW_TRUE};
    case (b) inside
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF:       a.newline = 1'b1;
      CH_LBRACE:   begin a.emit = 1'b1; a.kind = TK_LBRACE;   end
      CH_RBRACE:   begin a.emit = 1'b1; a.kind = TK_RBRACE;   end
      CH_LBRACKET: begin a.emit = 1'b1; a.kind = TK_LBRACKET; end
      CH_RBRACKET: begin a.emit = 1'b1; a.kind = TK_RBRACKET; end
      CH_COMMA:    begin a.emit = 1'b1; a.kind = TK_COMMA;    end
      CH_COLON:    begin a.emit = 1'b1; a.kind = TK_COLON;    end
      CH_QUOTE:    begin a.start = 1'b1; a.mode = MODE_STRING; end
      CH_T: begin a.start = 1'b1; a.mode = MODE_KEYWORD; a.kw_kind = KW_TRUE;  end
      CH_F: begin a.start = 1'b1; a.mode = MODE_KEYWORD; a.kw_kind = KW_FALSE; end
      CH_N: begin a.start = 1'b1; a.mode = MODE_KEYWORD; a.kw_kind = KW_NULL;  end
      [CH_0:CH_9]: begin a.start = 1'b1; a.mode = MODE_INT; end
      default: begin
        a.emit  = 1'b1;
        a.kind  = TK_ERROR;
        a.cause = EC_UNEXPECTED;
      end
    endcase
    return a;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] k, logic [KW_IDX_W-1:0] idx);
    logic [7:0] c;
    c = CH_NUL;
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      if (idx == KW_IDX_W'(i)) c = KW_TEXT[k][i];
    end
    return c;
  endfunction

  // Saturating add of a small increment to a byte position.
  function automatic logic [POS_BITS-1:0] pos_sat_add(logic [POS_BITS-1:0] a,
                                                      logic [2:0] inc);
    logic [POS_BITS:0] s;
    s = {1'b0, a} + (POS_BITS + 1)'(inc);
    return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
  endfunction

  function automatic logic [LINE_BITS-1:0] line_sat_inc(logic [LINE_BITS-1:0] a);
    return (&a) ? a : a + LINE_BITS'(1);
  endfunction

  function automatic token_t mk_tok(tok_kind_e k, err_cause_e c,
                                    logic [POS_BITS-1:0] off, logic [POS_BITS-1:0] len);
    token_t t;
    t.kind   = k;
    t.cause  = c;
    t.offset = off;
    t.length = len;
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/jts_in_if.sv @@
// Input channel of the JSON token scanner: one text byte or end marker per
// transaction. Depends on nothing.
`default_nettype none

interface jts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ rtl/jts_out_if.sv @@
// Output channel of the JSON token scanner: one token per transaction.
// Depends on jts_pkg for the field widths.
`default_nettype none

interface jts_out_if;
  import jts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [3:0]           token_kind;
  logic [2:0]           error_cause;
  logic [POS_BITS-1:0]  token_offset;
  logic [POS_BITS-1:0]  token_length;
  logic [LINE_BITS-1:0] line_number;
  logic                 last_of_run;

  modport source (output valid, output token_kind, output error_cause, output token_offset,
                  output token_length, output line_number, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input error_cause, input token_offset,
                  input token_length, input line_number, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/jts_step.sv @@
// Per-byte scanner decision: from the current state and one input byte or end
// marker, forms up to five tokens in order and the next state. Uses jts_pkg.
`default_nettype none

module jts_step (
  input  jts_pkg::scan_state_t          state_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_text_i,
  output jts_pkg::scan_state_t          state_o,
  output jts_pkg::tok_list_t            toks_o,
  output logic [jts_pkg::CNT_W-1:0]     count_o
);
  import jts_pkg::*;

  // Candidate token slots, in emission order.
  localparam int S_NUM    = 0;  // pending number
  localparam int S_DOT    = 1;  // held dot that turned out lone
  localparam int S_KWERR  = 2;  // keyword mismatch
  localparam int S_RESCAN = 3;  // three slots: held keyword letters rescanned
  localparam int S_SINGLE = 6;  // string, keyword, or unterminated string
  localparam int S_IDLE   = 7;  // current byte scanned between tokens
  localparam int S_END    = 8;  // end token

  token_t                cand [NUM_CAND];
  logic [NUM_CAND-1:0]   cand_en;
  idle_act_t             ia;
  logic                  num_char;
  logic [1:0]            k;
  logic [KW_IDX_W-1:0]   klen;
  logic [KW_IDX_W-1:0]   m_clip;
  logic [POS_BITS-1:0]   held;
  logic [POS_BITS-1:0]   span_len;
  logic                  do_flush;
  logic                  do_kwfail;
  logic                  do_idle;
  logic [CNT_W-1:0]      n;

  assign ia       = idle_decode(data_byte_i);
  assign num_char = (data_byte_i >= CH_0) && (data_byte_i <= CH_9);
  assign k        = state_i.kw_kind;
  assign klen     = KW_LEN[k];
  assign m_clip   = (state_i.kw_matched > klen) ? klen : state_i.kw_matched;
  assign held     = state_i.pos - state_i.tbegin;
  assign span_len = held + POS_BITS'(1);

  always_comb begin
    state_o   = state_i;
    do_flush  = 1'b0;
    do_kwfail = 1'b0;
    do_idle   = 1'b0;
    cand_en   = '0;
    for (int j = 0; j < NUM_CAND; j++) cand[j] = '0;
    cand[S_SINGLE] = mk_tok(TK_STRING, EC_NONE, state_i.tbegin, span_len);

    if (end_of_text_i) begin
      unique case (state_i.mode) inside
        MODE_INT, MODE_DOT, MODE_FRAC: do_flush = 1'b1;
        MODE_STRING: begin
          cand_en[S_SINGLE] = 1'b1;
          cand[S_SINGLE]    = mk_tok(TK_ERROR, EC_UNTERMINATED, state_i.tbegin, '0);
        end
        MODE_KEYWORD: do_kwfail = 1'b1;
        default: ;
      endcase
      state_o.mode     = MODE_IDLE;
      cand_en[S_END]   = 1'b1;
      cand[S_END]      = mk_tok(TK_END, EC_NONE, state_i.pos, '0);
    end else begin
      unique case (state_i.mode)
        MODE_INT: begin
          if (data_byte_i == CH_DOT) begin
            state_o.mode = MODE_DOT;
          end else if (!num_char) begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_DOT: begin
          if (num_char) begin
            state_o.mode = MODE_FRAC;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (!num_char) begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_STRING: begin
          // A quote right after a backslash never closes the string.
          if (data_byte_i == CH_QUOTE && state_i.prev != CH_BSLASH) begin
            cand_en[S_SINGLE] = 1'b1;
            state_o.mode      = MODE_IDLE;
          end else if (data_byte_i == CH_LF) begin
            state_o.line = line_sat_inc(state_i.line);
          end
        end
        MODE_KEYWORD: begin
          if (state_i.kw_matched < klen &&
              data_byte_i == kw_char(k, state_i.kw_matched)) begin
            state_o.kw_matched = state_i.kw_matched + KW_IDX_W'(1);
            if (state_o.kw_matched == klen) begin
              cand_en[S_SINGLE] = 1'b1;
              cand[S_SINGLE]    = mk_tok(KW_TOKEN[k], EC_NONE, state_i.tbegin, span_len);
              state_o.mode      = MODE_IDLE;
            end
          end else begin
            do_kwfail = 1'b1;
            do_idle   = 1'b1;
          end
        end
        default: begin
          state_o.mode = MODE_IDLE;
          do_idle      = 1'b1;
        end
      endcase
      state_o.prev = data_byte_i;
      state_o.pos  = pos_sat_add(state_i.pos, 3'd1);
    end

    // A pending number ends; a held dot goes out as its own error.
    if (do_flush) begin
      state_o.mode    = MODE_IDLE;
      cand_en[S_NUM]  = 1'b1;
      if (state_i.mode == MODE_DOT) begin
        cand[S_NUM]    = mk_tok(TK_NUMBER, EC_NONE, state_i.tbegin,
                                (held != '0) ? held - POS_BITS'(1) : '0);
        cand_en[S_DOT] = 1'b1;
        cand[S_DOT]    = mk_tok(TK_ERROR, EC_UNEXPECTED,
                                (held != '0) ? state_i.pos - POS_BITS'(1) : state_i.pos,
                                '0);
      end else begin
        cand[S_NUM]    = mk_tok(TK_NUMBER, EC_NONE, state_i.tbegin, held);
      end
    end

    // Keyword mismatch: error at the keyword, then each held letter after the
    // first is rescanned; none of them can start a token, so each is an error.
    if (do_kwfail) begin
      state_o.mode     = MODE_IDLE;
      cand_en[S_KWERR] = 1'b1;
      cand[S_KWERR]    = mk_tok(TK_ERROR, KW_CAUSE[k], state_i.tbegin, '0);
      for (int i = 1; i <= 3; i++) begin
        cand_en[S_RESCAN + i - 1] = (KW_IDX_W'(i) < m_clip);
        cand[S_RESCAN + i - 1]    = mk_tok(TK_ERROR, EC_UNEXPECTED,
                                           pos_sat_add(state_i.tbegin, 3'(i)), '0);
      end
    end

    if (do_idle) begin
      state_o.mode    = ia.start ? ia.mode : MODE_IDLE;
      cand_en[S_IDLE] = ia.emit;
      cand[S_IDLE]    = mk_tok(ia.kind, ia.cause, state_i.pos, POS_BITS'(ia.emit && ia.kind != TK_ERROR));
      if (ia.start) begin
        state_o.tbegin = state_i.pos;
        if (ia.mode == MODE_KEYWORD) begin
          state_o.kw_kind    = ia.kw_kind;
          state_o.kw_matched = KW_IDX_W'(1);
        end
      end
      if (ia.newline) state_o.line = line_sat_inc(state_i.line);
    end
  end

  // Pack the enabled candidates into the result list in order.
  always_comb begin
    toks_o = '0;
    n      = '0;
    for (int j = 0; j < NUM_CAND; j++) begin
      if (cand_en[j] && n < CNT_W'(MAX_RES)) begin
        toks_o[n] = cand[j];
        n         = n + CNT_W'(1);
      end
    end
    count_o = n;
  end

endmodule

`default_nettype wire

@@ rtl/json_token_scanner.sv @@
// A byte transaction is taken into the input register and decoded there; its tokens
// are then loaded into the result buffer, where the first is valid and can be taken.
// One byte per cycle while each byte yields at most one token and out_ch_o is ready;
// a byte that yields several tokens holds the result buffer until each has left. Reset
// (rst_ni low, asynchronous) empties both stages, leaving idle at offset 0, line 1.
// Top level of the JSON token scanner. Depends on jts_pkg, jts_in_if, jts_out_if, jts_step.
`default_nettype none

module json_token_scanner (
  input  logic             clk_i,
  input  logic             rst_ni,
  jts_in_if.sink           in_ch_i,
  jts_out_if.source        out_ch_o
);
  import jts_pkg::*;

  // Input register. It takes a new transaction whenever it is empty or its
  // current byte is loaded into the result buffer in the same cycle; the sender is held
  // off only while a decoded byte still waits for the result buffer to drain.
  logic        in_valid_q;
  logic [7:0]  in_data_q;
  logic        in_end_q;

  // Scanner state, updated once per decoded byte.
  scan_state_t state_q;
  scan_state_t state_d;

  // Result buffer: the tokens of one byte, head at index zero. All tokens of
  // one byte carry the line count from before that byte.
  tok_list_t              tok_q;
  tok_list_t              tok_d;
  logic [CNT_W-1:0]       cnt_q;
  logic [CNT_W-1:0]       cnt_d;
  logic [LINE_BITS-1:0]   line_tok_q;

  logic in_take;
  logic out_take;
  logic load;

  jts_step u_step (
    .state_i       (state_q),
    .data_byte_i   (in_data_q),
    .end_of_text_i (in_end_q),
    .state_o       (state_d),
    .toks_o        (tok_d),
    .count_o       (cnt_d)
  );

  assign out_take = out_ch_o.valid && out_ch_o.ready;

  // A decoded byte may enter the buffer once the buffer is empty, or as its
  // last token leaves. A byte with no tokens still passes through here.
  assign load = in_valid_q &&
                (cnt_q == '0 || (cnt_q == CNT_W'(1) && out_ch_o.ready));

  assign in_ch_i.ready = !in_valid_q || load;
  assign in_take       = in_ch_i.valid && in_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_ch_i.data_byte;
      in_end_q  <= in_ch_i.end_of_text;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode       <= MODE_IDLE;
      state_q.pos        <= '0;
      state_q.line       <= LINE_BITS'(1);
      state_q.tbegin     <= '0;
      state_q.prev       <= '0;
      state_q.kw_kind    <= '0;
      state_q.kw_matched <= '0;
      cnt_q              <= '0;
    end else if (load) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end else if (out_take) begin
      cnt_q   <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q      <= tok_d;
      line_tok_q <= state_q.line;
    end else if (out_take) begin
      tok_q      <= {token_t'('0), tok_q[MAX_RES-1:1]};
    end
  end

  assign out_ch_o.valid        = (cnt_q != '0);
  assign out_ch_o.token_kind   = tok_q[0].kind;
  assign out_ch_o.error_cause  = tok_q[0].cause;
  assign out_ch_o.token_offset = tok_q[0].offset;
  assign out_ch_o.token_length = tok_q[0].length;
  assign out_ch_o.line_number  = line_tok_q;
  assign out_ch_o.last_of_run  = (cnt_q == CNT_W'(1));

  // The buffer never holds more tokens than one byte can produce.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RES))
    else $error("result buffer count out of range");

  // The buffer is loaded with exactly the decoder's token count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> cnt_q == $past(cnt_d))
    else $error("buffer count does not match decoded byte");

  // After an end marker is decoded the scanner is between tokens.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_end_q) |=> state_q.mode == MODE_IDLE)
    else $error("scanner not idle after end marker");

  // A held byte is never dropped before it is decoded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !load) |=> in_valid_q && $stable(in_data_q))
    else $error("held input byte lost");

  // The line count never wraps to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.line != '0)
    else $error("line count reached zero");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the JSON token scanner: drives text bytes and end
// markers, predicts every token in its own lexer model and checks each one.
// Depends on jts_pkg, jts_in_if, jts_out_if and json_token_scanner.
`default_nettype none

module tb;
  import jts_pkg::*;

  // Longest legal stretch without any transaction is the forced output stall
  // plus the pipeline latency; the watchdog allows far more.
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;
  localparam int TEXT_ITEMS  = 128;

  // One pending input transaction. A drain item is not offered until every
  // predicted token has been received.
  typedef struct {
    logic [7:0] data;
    logic       eot;
    logic       drain;
  } text_item_t;

  // One predicted token, in the order the output channel must deliver it.
  typedef struct packed {
    tok_kind_e            kind;
    err_cause_e           cause;
    logic [POS_BITS-1:0]  offset;
    logic [POS_BITS-1:0]  length;
    logic [LINE_BITS-1:0] line;
    logic                 run_end;
  } token_rec_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jts_in_if  in_ch ();
  jts_out_if out_ch ();

  json_token_scanner dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  text_item_t text_q[$];
  token_rec_t expected_tokens[$];
  logic       drain_pending = 1'b0;

  // Lexer model state.
  mode_e                lex_mode   = MODE_IDLE;
  logic [POS_BITS-1:0]  next_offset = '0;
  logic [LINE_BITS-1:0] cur_line   = LINE_BITS'(1);
  logic [POS_BITS-1:0]  tok_start  = '0;
  logic [7:0]           last_byte  = 8'h00;
  logic [1:0]           kw_sel     = KW_TRUE;
  logic [2:0]           kw_hits    = 3'd0;
  int                   run_count;

  // Bookkeeping shared by the driver, receiver and monitor.
  logic in_taken    = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;
  int   items_in    = 0;
  int   quiet_cycles = 0;
  int   mismatches  = 0;
  logic steady;

  // A window of the run with no random idling on either side.
  assign steady = (items_in >= 85) && (items_in < 115);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Lexer model
  // ---------------------------------------------------------------------------

  function automatic logic [POS_BITS-1:0] pos_add_sat(logic [POS_BITS-1:0] a, int inc);
    logic [POS_BITS:0] s;
    s = {1'b0, a} + (POS_BITS + 1)'(inc);
    return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
  endfunction

  function automatic logic [7:0] kw_letter(logic [1:0] k, int i);
    logic [39:0] w;
    case (k)
      KW_TRUE:  w = {"true", 8'h00};
      KW_FALSE: w = "false";
      default:  w = {"null", 8'h00};
    endcase
    return w[39 - 8 * i -: 8];
  endfunction

  function automatic logic [2:0] kw_size(logic [1:0] k);
    return (k == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic tok_kind_e kw_token(logic [1:0] k);
    case (k)
      KW_TRUE:  return TK_TRUE;
      KW_FALSE: return TK_FALSE;
      default:  return TK_NULL;
    endcase
  endfunction

  function automatic logic digit_char(logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // Appends a token to the current run; a single byte never yields more than
  // MAX_RES tokens, and any beyond that are dropped.
  task automatic push_token(tok_kind_e k, err_cause_e c, logic [POS_BITS-1:0] offs,
                            logic [POS_BITS-1:0] len);
    token_rec_t t;
    if (run_count < MAX_RES) begin
      t.kind    = k;
      t.cause   = c;
      t.offset  = offs;
      t.length  = len;
      t.line    = cur_line;
      t.run_end = 1'b0;
      expected_tokens.push_back(t);
      run_count++;
    end
  endtask

  // A byte seen between tokens: single-byte tokens, whitespace, token starts
  // and unexpected bytes.
  task automatic lex_between(logic [7:0] b, logic [POS_BITS-1:0] offs);
    case (b) inside
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF: if (cur_line != '1) cur_line = cur_line + LINE_BITS'(1);
      CH_LBRACE:   push_token(TK_LBRACE, EC_NONE, offs, POS_BITS'(1));
      CH_RBRACE:   push_token(TK_RBRACE, EC_NONE, offs, POS_BITS'(1));
      CH_LBRACKET: push_token(TK_LBRACKET, EC_NONE, offs, POS_BITS'(1));
      CH_RBRACKET: push_token(TK_RBRACKET, EC_NONE, offs, POS_BITS'(1));
      CH_COMMA:    push_token(TK_COMMA, EC_NONE, offs, POS_BITS'(1));
      CH_COLON:    push_token(TK_COLON, EC_NONE, offs, POS_BITS'(1));
      CH_QUOTE: begin
        lex_mode  = MODE_STRING;
        tok_start = offs;
      end
      CH_T, CH_F, CH_N: begin
        lex_mode  = MODE_KEYWORD;
        kw_sel    = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE : KW_NULL;
        kw_hits   = 3'd1;
        tok_start = offs;
      end
      default: begin
        if (digit_char(b)) begin
          lex_mode  = MODE_INT;
          tok_start = offs;
        end else begin
          push_token(TK_ERROR, EC_UNEXPECTED, offs, '0);
        end
      end
    endcase
  endtask

  // Closes a pending number at offs. A dangling dot is not part of the number:
  // it is rescanned on its own and turns into an unexpected-byte error.
  task automatic close_number(logic [POS_BITS-1:0] offs);
    logic [POS_BITS-1:0] held;
    mode_e               was;
    held     = offs - tok_start;
    was      = lex_mode;
    lex_mode = MODE_IDLE;
    if (was == MODE_DOT) begin
      push_token(TK_NUMBER, EC_NONE, tok_start, (held != '0) ? held - POS_BITS'(1) : '0);
      lex_between(CH_DOT, (held != '0) ? offs - POS_BITS'(1) : offs);
    end else begin
      push_token(TK_NUMBER, EC_NONE, tok_start, held);
    end
  endtask

  // A keyword that did not match: one error for the keyword, then every held
  // letter after the first is scanned again as an ordinary byte.
  task automatic reject_keyword();
    logic [2:0] held;
    held = (kw_hits > kw_size(kw_sel)) ? kw_size(kw_sel) : kw_hits;
    lex_mode = MODE_IDLE;
    push_token(TK_ERROR, (kw_sel == KW_TRUE || kw_sel == KW_FALSE) ? EC_BAD_BOOL : EC_BAD_NULL,
               tok_start, '0);
    for (int i = 1; i < held; i++) begin
      lex_between(kw_letter(kw_sel, i), pos_add_sat(tok_start, i));
    end
  endtask

  // Predicts the token run caused by one accepted transaction.
  task automatic predict_tokens(logic [7:0] b, logic eot);
    logic [POS_BITS-1:0] here;
    here      = next_offset;
    run_count = 0;
    if (eot) begin
      case (lex_mode) inside
        MODE_INT, MODE_DOT, MODE_FRAC: close_number(here);
        MODE_STRING:  push_token(TK_ERROR, EC_UNTERMINATED, tok_start, '0);
        MODE_KEYWORD: reject_keyword();
        default: ;
      endcase
      lex_mode = MODE_IDLE;
      push_token(TK_END, EC_NONE, here, '0);
    end else begin
      case (lex_mode)
        MODE_INT: begin
          if (b == CH_DOT) begin
            lex_mode = MODE_DOT;
          end else if (!digit_char(b)) begin
            close_number(here);
            lex_between(b, here);
          end
        end
        MODE_DOT: begin
          if (digit_char(b)) begin
            lex_mode = MODE_FRAC;
          end else begin
            close_number(here);
            lex_between(b, here);
          end
        end
        MODE_FRAC: begin
          if (!digit_char(b)) begin
            close_number(here);
            lex_between(b, here);
          end
        end
        MODE_STRING: begin
          // Any quote right after a backslash is escaped, even when that
          // backslash is itself escaped.
          if (b == CH_QUOTE && last_byte != CH_BSLASH) begin
            push_token(TK_STRING, EC_NONE, tok_start, here - tok_start + POS_BITS'(1));
            lex_mode = MODE_IDLE;
          end else if (b == CH_LF && cur_line != '1) begin
            cur_line = cur_line + LINE_BITS'(1);
          end
        end
        MODE_KEYWORD: begin
          if (kw_hits < kw_size(kw_sel) && b == kw_letter(kw_sel, kw_hits)) begin
            kw_hits = kw_hits + 3'd1;
            if (kw_hits == kw_size(kw_sel)) begin
              push_token(kw_token(kw_sel), EC_NONE, tok_start,
                         here - tok_start + POS_BITS'(1));
              lex_mode = MODE_IDLE;
            end
          end else begin
            reject_keyword();
            lex_between(b, here);
          end
        end
        default: begin
          lex_mode = MODE_IDLE;
          lex_between(b, here);
        end
      endcase
      last_byte   = b;
      next_offset = pos_add_sat(next_offset, 1);
    end
    if (run_count > 0) expected_tokens[expected_tokens.size() - 1].run_end = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_byte(logic [7:0] b);
    text_item_t it;
    it.data  = b;
    it.eot   = 1'b0;
    it.drain = drain_pending;
    drain_pending = 1'b0;
    text_q.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // The data byte of an end marker is ignored, so it carries random bits.
  task automatic add_end();
    text_item_t it;
    it.data  = 8'($urandom);
    it.eot   = 1'b1;
    it.drain = drain_pending;
    drain_pending = 1'b0;
    text_q.push_back(it);
  endtask

  task automatic check_token();
    token_rec_t want;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected token: kind %0d cause %0d offset %0d length %0d line %0d last %0b",
                 out_ch.token_kind, out_ch.error_cause, out_ch.token_offset,
                 out_ch.token_length, out_ch.line_number, out_ch.last_of_run);
    end else begin
      want = expected_tokens.pop_front();
      if (out_ch.token_kind !== want.kind || out_ch.error_cause !== want.cause ||
          out_ch.token_offset !== want.offset || out_ch.token_length !== want.length ||
          out_ch.line_number !== want.line || out_ch.last_of_run !== want.run_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("token mismatch: expected kind %0d cause %0d offset %0d length %0d line %0d last %0b",
                   want.kind, want.cause, want.offset, want.length, want.line, want.run_end);
          $display("                actual   kind %0d cause %0d offset %0d length %0d line %0d last %0b",
                   out_ch.token_kind, out_ch.error_cause, out_ch.token_offset,
                   out_ch.token_length, out_ch.line_number, out_ch.last_of_run);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next byte at the falling edge once the previous
  // transaction has been taken, with random gaps and drain pauses.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    text_item_t item;
    logic       hold;
    if (rst_ni && (!in_ch.valid || in_taken)) begin
      hold = (text_q.size() == 0) || (!steady && ($urandom_range(99) < 9));
      if (!hold && text_q[0].drain && expected_tokens.size() != 0) hold = 1'b1;
      if (hold) begin
        in_ch.valid <= 1'b0;
      end else begin
        item = text_q.pop_front();
        in_ch.data_byte   <= item.data;
        in_ch.end_of_text <= item.eot;
        in_ch.valid       <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long stall once the stream is
  // well under way so that the scanner fills up and stops taking bytes.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        out_ch.ready  <= 1'b0;
      end else if (!hold_done && items_in >= 60) begin
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        out_ch.ready  <= 1'b0;
      end else begin
        out_ch.ready  <= steady || ($urandom_range(99) >= 9);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, predicts the tokens of an accepted byte and
  // checks an accepted token against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_tokens(in_ch.data_byte, in_ch.end_of_text);
        items_in <= items_in + 1;
      end
      if (out_ch.valid && out_ch.ready) check_token();
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a run that stops moving for too long has hung.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int         pick;
    int         n;
    int         k;
    int         len;
    logic [7:0] c;
    logic       late_drain;

    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    late_drain        = 1'b0;

    // Directed part: punctuation, a string with an escaped quote, a number
    // with a fraction, a failed "false" that yields a full run of five tokens,
    // a lone dot, the byte extremes, and an end marker inside a keyword, a
    // string and a number.
    add_text("{\"\\\"\":1.5,");
    add_text("falsx");
    drain_pending = 1'b1;
    add_text("7.]\n");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("n");
    add_end();
    add_text("\"");
    add_end();
    add_text("9");
    add_end();

    // Random part: mostly well-formed token fragments with random content,
    // mixed with noise bytes, broken keywords and stray end markers.
    while (text_q.size() < TEXT_ITEMS) begin
      if (!late_drain && text_q.size() >= 110) begin
        drain_pending = 1'b1;
        late_drain    = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 14) begin
        case ($urandom_range(5))
          0: add_byte(CH_LBRACE);
          1: add_byte(CH_RBRACE);
          2: add_byte(CH_LBRACKET);
          3: add_byte(CH_RBRACKET);
          4: add_byte(CH_COMMA);
          default: add_byte(CH_COLON);
        endcase
      end else if (pick < 24) begin
        case ($urandom_range(3))
          0: add_byte(CH_SPACE);
          1: add_byte(CH_TAB);
          2: add_byte(CH_CR);
          default: add_byte(CH_LF);
        endcase
      end else if (pick < 42) begin
        n = $urandom_range(3, 1);
        repeat (n) add_byte(8'(CH_0 + $urandom_range(9)));
        if ($urandom_range(9) < 3) begin
          // Zero fraction digits leaves a lone dot.
          add_byte(CH_DOT);
          n = $urandom_range(2);
          repeat (n) add_byte(8'(CH_0 + $urandom_range(9)));
        end
      end else if (pick < 60) begin
        add_byte(CH_QUOTE);
        n = $urandom_range(5);
        repeat (n) begin
          case ($urandom_range(7))
            0: c = 8'($urandom_range(255, 128));
            1: c = CH_LF;
            default: c = 8'($urandom_range(126, 32));
          endcase
          if (c == CH_QUOTE) add_byte(CH_BSLASH);
          add_byte(c);
        end
        // Now and then the string is left open and swallows what follows.
        if ($urandom_range(9) != 0) add_byte(CH_QUOTE);
      end else if (pick < 80) begin
        k   = $urandom_range(2);
        len = kw_size(2'(k));
        if ($urandom_range(3) != 0) begin
          for (int i = 0; i < len; i++) add_byte(kw_letter(2'(k), i));
        end else begin
          n = $urandom_range(len - 1, 1);
          for (int i = 0; i < n; i++) add_byte(kw_letter(2'(k), i));
          add_byte(8'($urandom_range(126, 32)));
        end
      end else if (pick < 93) begin
        add_byte(8'($urandom));
      end else begin
        add_end();
      end
    end
    add_end();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (text_q.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
